### hdl/spcd_pkg.sv
// Package for the sphere pair contact detector: widths, pipeline depths and
// the word types that travel between the pipeline stages. No dependencies.
package spcd_pkg;

  localparam int CoordW  = 32;
  localparam int RadW    = 31;
  localparam int IdW     = 16;
  localparam int DepthW  = 33;
  localparam int NormW   = 32;
  localparam int NormBits = 30;
  localparam int DiffW   = 33;   // signed coordinate difference
  localparam int MagW    = 32;   // magnitude of a difference below the radius sum
  localparam int SumW    = 32;   // radius sum
  localparam int SqW     = 64;   // squared distance
  localparam int DistW   = 32;   // rounded distance, at most 2^32 - 1
  localparam int SqrtSteps = 32; // one result bit per stage
  localparam int DivQW   = 31;   // normal magnitude, at most 2^30
  localparam int DivSteps = DivQW;

  typedef struct packed {
    logic [IdW-1:0]    id_a;
    logic [IdW-1:0]    id_b;
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic [CoordW-1:0] point_z;
  } side_t;

  // Record leaving the distance section and entering the normal divider.
  typedef struct packed {
    logic              hit;
    logic [DepthW-1:0] depth;
    logic [DistW-1:0]  root;
    logic [MagW-1:0]   mag_x;
    logic [MagW-1:0]   mag_y;
    logic [MagW-1:0]   mag_z;
    logic              neg_x;
    logic              neg_y;
    logic              neg_z;
    side_t             side;
  } dist_word_t;

endpackage

### hdl/spcd_dist.sv
// Distance section: differences, squares, contact test and a pipelined
// restoring square root with round to nearest. Uses spcd_pkg.
module spcd_dist (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic signed [spcd_pkg::CoordW-1:0] a_x,
  input  logic signed [spcd_pkg::CoordW-1:0] a_y,
  input  logic signed [spcd_pkg::CoordW-1:0] a_z,
  input  logic signed [spcd_pkg::CoordW-1:0] b_x,
  input  logic signed [spcd_pkg::CoordW-1:0] b_y,
  input  logic signed [spcd_pkg::CoordW-1:0] b_z,
  input  logic [spcd_pkg::RadW-1:0]        radius_a,
  input  logic [spcd_pkg::RadW-1:0]        radius_b,
  input  logic [spcd_pkg::IdW-1:0]         id_a,
  input  logic [spcd_pkg::IdW-1:0]         id_b,
  output logic                             out_valid,
  output spcd_pkg::dist_word_t             out_word
);
  import spcd_pkg::*;

  localparam int NS = SqrtSteps;

  // Stage 1: differences, magnitudes, radius sum, midpoints and the far test.
  logic              v1;
  logic [MagW-1:0]   m1 [3];
  logic              n1 [3];
  logic              far1;
  logic [SumW-1:0]   q1;
  side_t             s1;

  logic signed [DiffW-1:0] dx, dy, dz;
  logic [DiffW-1:0]        ax, ay, az;
  logic [SumW-1:0]         qs;
  logic signed [DiffW-1:0] px, py, pz;

  always_comb begin
    dx = DiffW'(a_x) - DiffW'(b_x);
    dy = DiffW'(a_y) - DiffW'(b_y);
    dz = DiffW'(a_z) - DiffW'(b_z);
    ax = dx[DiffW-1] ? -dx : dx;
    ay = dy[DiffW-1] ? -dy : dy;
    az = dz[DiffW-1] ? -dz : dz;
    qs = SumW'(radius_a) + SumW'(radius_b);
    px = DiffW'(a_x) + DiffW'(b_x);
    py = DiffW'(a_y) + DiffW'(b_y);
    pz = DiffW'(a_z) + DiffW'(b_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      far1  <= (ax >= DiffW'(qs)) || (ay >= DiffW'(qs)) || (az >= DiffW'(qs));
      m1[0] <= ax[MagW-1:0];
      m1[1] <= ay[MagW-1:0];
      m1[2] <= az[MagW-1:0];
      n1[0] <= dx[DiffW-1];
      n1[1] <= dy[DiffW-1];
      n1[2] <= dz[DiffW-1];
      q1    <= qs;
      s1.id_a    <= id_a;
      s1.id_b    <= id_b;
      s1.point_x <= px[DiffW-1:1];
      s1.point_y <= py[DiffW-1:1];
      s1.point_z <= pz[DiffW-1:1];
    end
  end

  // Stage 2: the three squares and the squared radius sum.
  logic            v2, far2;
  logic [SqW-1:0]  sq2 [3];
  logic [SqW-1:0]  qq2;
  logic [MagW-1:0] m2 [3];
  logic            n2 [3];
  logic [SumW-1:0] q2;
  side_t           s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      far2 <= far1;
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= SqW'(m1[i]) * SqW'(m1[i]);
        m2[i]  <= m1[i];
        n2[i]  <= n1[i];
      end
      qq2 <= SqW'(q1) * SqW'(q1);
      q2  <= q1;
      s2  <= s1;
    end
  end

  // Stage 3: sum of squares (with carry) and the strict contact compare.
  logic              v3, hit3;
  logic [SqW-1:0]    p3;
  logic [MagW-1:0]   m3 [3];
  logic              n3 [3];
  logic [SumW-1:0]   q3;
  side_t             s3;
  logic [SqW+1:0]    psum;

  assign psum = (SqW+2)'(sq2[0]) + (SqW+2)'(sq2[1]) + (SqW+2)'(sq2[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      hit3 <= !far2 && (psum[SqW+1:SqW] == 2'b00) && (psum[SqW-1:0] < qq2);
      p3   <= psum[SqW-1:0];
      m3   <= m2;
      n3   <= n2;
      q3   <= q2;
      s3   <= s2;
    end
  end

  // Square root: one result bit per stage, remainder kept for rounding.
  logic            sv   [NS+1];
  logic            sh   [NS+1];
  logic [SqW-1:0]  srad [NS+1];
  logic [DistW-1:0] sres [NS+1];
  logic [DistW+1:0] srem [NS+1];
  logic [MagW-1:0] sm   [NS+1][3];
  logic            sn   [NS+1][3];
  logic [SumW-1:0] sq   [NS+1];
  side_t           ss   [NS+1];

  always_comb begin
    sv[0]   = v3;
    sh[0]   = hit3;
    srad[0] = p3;
    sres[0] = '0;
    srem[0] = '0;
    sm[0]   = m3;
    sn[0]   = n3;
    sq[0]   = q3;
    ss[0]   = s3;
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [DistW+1:0] trial;
    logic [DistW+1:0] cand;
    assign trial = {srem[k][DistW-1:0], srad[k][SqW-1 -: 2]};
    assign cand  = {sres[k], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
      if (adv) begin
        sh[k+1]   <= sh[k];
        srad[k+1] <= {srad[k][SqW-3:0], 2'b00};
        if (trial >= cand) begin
          srem[k+1] <= trial - cand;
          sres[k+1] <= {sres[k][DistW-2:0], 1'b1};
        end else begin
          srem[k+1] <= trial;
          sres[k+1] <= {sres[k][DistW-2:0], 1'b0};
        end
        sm[k+1] <= sm[k];
        sn[k+1] <= sn[k];
        sq[k+1] <= sq[k];
        ss[k+1] <= ss[k];
      end
    end
  end

  // Final stage: round to nearest, depth, clear the record on a miss.
  logic [DistW-1:0]  droot;
  logic [DistW-1:0]  dist_r;
  logic [DepthW-1:0] depth_c;

  always_comb begin
    droot   = sres[NS];
    dist_r  = (srem[NS] > (DistW+2)'(droot)) ? droot + DistW'(1) : droot;
    depth_c = DepthW'(dist_r) - DepthW'(sq[NS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sv[NS];
    end
    if (adv) begin
      if (sh[NS]) begin
        out_word.hit   <= 1'b1;
        out_word.depth <= depth_c;
        out_word.root  <= dist_r;
        out_word.mag_x <= sm[NS][0];
        out_word.mag_y <= sm[NS][1];
        out_word.mag_z <= sm[NS][2];
        out_word.neg_x <= sn[NS][0];
        out_word.neg_y <= sn[NS][1];
        out_word.neg_z <= sn[NS][2];
        out_word.side  <= ss[NS];
      end else begin
        out_word <= '0;
      end
    end
  end

endmodule

### hdl/spcd_norm.sv
// Normal section: three pipelined restoring dividers giving
// round(|d| * 2^30 / dist) per axis, then the sign. Uses spcd_pkg.
module spcd_norm (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  spcd_pkg::dist_word_t   in_word,
  output logic                   out_valid,
  output logic                   hit,
  output logic [spcd_pkg::DepthW-1:0] overlap_depth,
  output logic [spcd_pkg::NormW-1:0]  normal_x,
  output logic [spcd_pkg::NormW-1:0]  normal_y,
  output logic [spcd_pkg::NormW-1:0]  normal_z,
  output spcd_pkg::side_t        side
);
  import spcd_pkg::*;

  // Dividend is 2*|d|*2^30 + dist; dividing by 2*dist gives the rounded
  // quotient. As |d| < dist + 1 the quotient fits in DivQW bits, so the
  // partial remainder (below 2*dist) never needs more than DistW+2 bits.
  localparam int NumW = MagW + NormBits + 2;
  localparam int RemW = DistW + 2;
  localparam int ND   = DivSteps;

  logic             dv   [ND+1];
  dist_word_t       dw   [ND+1];
  logic [NumW-1:0]  num  [ND+1][3];
  logic [RemW-1:0]  rem  [ND+1][3];
  logic [DivQW-1:0] quo  [ND+1][3];

  logic [MagW-1:0]  mags [3];
  assign mags[0] = in_word.mag_x;
  assign mags[1] = in_word.mag_y;
  assign mags[2] = in_word.mag_z;

  always_comb begin
    dv[0] = in_valid;
    dw[0] = in_word;
    for (int i = 0; i < 3; i++) begin
      num[0][i] = {mags[i], 1'b0, {NormBits{1'b0}}} + NumW'(in_word.root);
      // Top bits that lie above the quotient window start the remainder.
      rem[0][i] = RemW'(num[0][i][NumW-1:DivQW]);
      num[0][i] = {num[0][i][DivQW-1:0], {(NumW-DivQW){1'b0}}};
      quo[0][i] = '0;
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [RemW-1:0] trial [3];
    logic [RemW-1:0] dvs;
    assign dvs = {1'b0, dw[k].root, 1'b0};
    for (genvar i = 0; i < 3; i++) begin : g_ax
      assign trial[i] = {rem[k][i][RemW-2:0], num[k][i][NumW-1]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
      if (adv) begin
        dw[k+1] <= dw[k];
        for (int i = 0; i < 3; i++) begin
          num[k+1][i] <= {num[k][i][NumW-2:0], 1'b0};
          if (trial[i] >= dvs) begin
            rem[k+1][i] <= trial[i] - dvs;
            quo[k+1][i] <= {quo[k][i][DivQW-2:0], 1'b1};
          end else begin
            rem[k+1][i] <= trial[i];
            quo[k+1][i] <= {quo[k][i][DivQW-2:0], 1'b0};
          end
        end
      end
    end
  end

  logic [NormW-1:0] mq [3];
  logic             ng [3];
  always_comb begin
    ng[0] = dw[ND].neg_x;
    ng[1] = dw[ND].neg_y;
    ng[2] = dw[ND].neg_z;
    for (int i = 0; i < 3; i++) begin
      mq[i] = (dw[ND].root == '0) ? '0 : NormW'(quo[ND][i]);
      if (ng[i]) begin
        mq[i] = -mq[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[ND];
    end
    if (adv) begin
      hit           <= dw[ND].hit;
      overlap_depth <= dw[ND].depth;
      normal_x      <= mq[0];
      normal_y      <= mq[1];
      normal_z      <= mq[2];
      side          <= dw[ND].side;
    end
  end

endmodule

### hdl/sphere_pair_contact_detect_unit.sv
// Sphere pair contact detector, top level: distance section, normal section
// and the output skid register. Uses spcd_pkg, spcd_dist and spcd_norm.
//
// The unit takes one sphere pair word per cycle while in_stall is low and
// gives one contact word for every pair, in order. A pair passes through the
// stages for differences, squares and the contact compare, the bit-per-stage
// square root, a rounding stage, the three parallel normal dividers and an
// output stage that applies the sign. The pipeline advances as a whole
// whenever the skid register is empty; a stalled result is held in the skid
// register so the input stall is a registered signal, and the pipeline
// halts while the skid holds a word. A miss gives hit = 0 with all other
// fields zero; coincident centres give a zero normal.
module sphere_pair_contact_detect_unit
  import spcd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [CoordW-1:0]  a_x,
  input  logic signed [CoordW-1:0]  a_y,
  input  logic signed [CoordW-1:0]  a_z,
  input  logic signed [CoordW-1:0]  b_x,
  input  logic signed [CoordW-1:0]  b_y,
  input  logic signed [CoordW-1:0]  b_z,
  input  logic [RadW-1:0]           radius_a,
  input  logic [RadW-1:0]           radius_b,
  input  logic [IdW-1:0]            id_a,
  input  logic [IdW-1:0]            id_b,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      hit,
  output logic signed [DepthW-1:0]  overlap_depth,
  output logic signed [NormW-1:0]   normal_x,
  output logic signed [NormW-1:0]   normal_y,
  output logic signed [NormW-1:0]   normal_z,
  output logic signed [CoordW-1:0]  point_x,
  output logic signed [CoordW-1:0]  point_y,
  output logic signed [CoordW-1:0]  point_z,
  output logic [IdW-1:0]            out_id_a,
  output logic [IdW-1:0]            out_id_b
);

  // The pipeline moves whenever the skid register is empty. The skid
  // register catches the word shown while out_stall is high, since the advance
  // does not look at out_stall, so in_stall can simply mirror "skid full".
  logic             adv;
  logic             dist_v, norm_v;
  dist_word_t       dist_w;
  logic             n_hit;
  logic [DepthW-1:0] n_depth;
  logic [NormW-1:0] n_nx, n_ny, n_nz;
  side_t            n_side;

  logic             skid_full;
  logic             skid_hit;
  logic [DepthW-1:0] skid_depth;
  logic [NormW-1:0] skid_nx, skid_ny, skid_nz;
  side_t            skid_side;

  // Pipeline output is presented directly unless the skid holds a word.
  assign adv      = !skid_full;
  assign in_stall = skid_full;

  spcd_dist u_dist (
    .clk, .rst, .adv, .in_valid,
    .a_x, .a_y, .a_z, .b_x, .b_y, .b_z,
    .radius_a, .radius_b, .id_a, .id_b,
    .out_valid (dist_v),
    .out_word  (dist_w)
  );

  spcd_norm u_norm (
    .clk, .rst, .adv,
    .in_valid      (dist_v),
    .in_word       (dist_w),
    .out_valid     (norm_v),
    .hit           (n_hit),
    .overlap_depth (n_depth),
    .normal_x      (n_nx),
    .normal_y      (n_ny),
    .normal_z      (n_nz),
    .side          (n_side)
  );

  // When the skid is empty the final pipeline register is the output word.
  // If it is shown but stalled, it moves into the skid since the pipeline
  // would otherwise overwrite it on the next advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!out_stall) begin
        skid_full <= 1'b0;
      end
    end else if (norm_v && out_stall) begin
      skid_full <= 1'b1;
    end
    if (!skid_full) begin
      skid_hit   <= n_hit;
      skid_depth <= n_depth;
      skid_nx    <= n_nx;
      skid_ny    <= n_ny;
      skid_nz    <= n_nz;
      skid_side  <= n_side;
    end
  end

  always_comb begin
    out_valid     = skid_full || norm_v;
    hit           = skid_full ? skid_hit   : n_hit;
    overlap_depth = skid_full ? skid_depth : n_depth;
    normal_x      = skid_full ? skid_nx    : n_nx;
    normal_y      = skid_full ? skid_ny    : n_ny;
    normal_z      = skid_full ? skid_nz    : n_nz;
    point_x       = skid_full ? skid_side.point_x : n_side.point_x;
    point_y       = skid_full ? skid_side.point_y : n_side.point_y;
    point_z       = skid_full ? skid_side.point_z : n_side.point_z;
    out_id_a      = skid_full ? skid_side.id_a : n_side.id_a;
    out_id_b      = skid_full ? skid_side.id_b : n_side.id_b;
  end

endmodule
